// File: design/dcfp_pkg.sv
// Shared types, register codes and constants for the disc cursor frame pixel generator.
package dcfp_pkg;

  // Register indexes on the configuration write channel
  typedef enum logic [2:0] {
    CFG_FRAME_SIZE_MODE = 3'd0,
    CFG_PIXEL_FORMAT    = 3'd1,
    CFG_MIRROR_X        = 3'd2,
    CFG_DISC_LUMA       = 3'd3,
    CFG_DISC_CB         = 3'd4,
    CFG_DISC_CR         = 3'd5
  } cfg_index_e;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 8;

  // Field codes
  localparam logic       SIZE_640X480 = 1'b0;
  localparam logic       SIZE_320X240 = 1'b1;
  localparam logic       FMT_YU12     = 1'b0;
  localparam logic       FMT_YUYV     = 1'b1;
  localparam logic [1:0] PLANE_Y      = 2'd0;
  localparam logic [1:0] PLANE_U      = 2'd1;
  localparam logic [1:0] PLANE_V      = 2'd2;

  // Register reset values
  localparam logic [7:0] RST_DISC_LUMA = 8'd220;
  localparam logic [7:0] RST_DISC_CB   = 8'd219;
  localparam logic [7:0] RST_DISC_CR   = 8'd179;

  // Background and pointer space
  localparam logic [7:0]  BG_LUMA     = 8'd48;
  localparam logic [7:0]  BG_CHROMA   = 8'd128;
  localparam logic [11:0] PTR_X_LIMIT = 12'd1280;
  localparam logic [11:0] PTR_Y_LIMIT = 12'd720;
  localparam logic [10:0] PTR_X_MAX   = 11'd1279;

  // floor(n / 3) == (n * 683) >> 11 for every n below 2048
  localparam logic [10:0] RECIP3       = 11'd683;
  localparam int unsigned Recip3Shift  = 11;

  // Frame geometry
  localparam logic [9:0] WIDTH_FULL  = 10'd640;
  localparam logic [9:0] WIDTH_HALF  = 10'd320;
  localparam logic [8:0] HEIGHT_FULL = 9'd480;
  localparam logic [8:0] HEIGHT_HALF = 9'd240;

  // Squared radii: width/24 at each size, and half of that for chroma planes
  localparam logic [9:0] RSQ_640      = 10'd676;  // 26 * 26
  localparam logic [9:0] RSQ_320      = 10'd169;  // 13 * 13
  localparam logic [9:0] RSQ_640_CHR  = 10'd169;  // 13 * 13
  localparam logic [9:0] RSQ_320_CHR  = 10'd36;   // 6 * 6

  typedef struct packed {
    logic [11:0] pointer_x;
    logic [11:0] pointer_y;
    logic        pointer_present;
    logic [9:0]  col;
    logic [8:0]  row;
    logic [1:0]  plane;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       second_valid;
    logic       in_disc;
  } pix_out_t;

  typedef struct packed {
    logic       frame_size_mode;
    logic       pixel_format;
    logic       mirror_x;
    logic [7:0] disc_luma;
    logic [7:0] disc_cb;
    logic [7:0] disc_cr;
  } cfg_t;

endpackage

// File: design/dcfp_cfg_regs.sv
// Configuration register file written through the valid/ready config channel.
module dcfp_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcfp_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [dcfp_pkg::CfgDataWidth-1:0]   cfg_data_i,
  output dcfp_pkg::cfg_t                      cfg_o
);
  import dcfp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_SIZE_MODE: cfg_d.frame_size_mode = cfg_data_i[0];
        CFG_PIXEL_FORMAT:    cfg_d.pixel_format    = cfg_data_i[0];
        CFG_MIRROR_X:        cfg_d.mirror_x        = cfg_data_i[0];
        CFG_DISC_LUMA:       cfg_d.disc_luma       = cfg_data_i;
        CFG_DISC_CB:         cfg_d.disc_cb         = cfg_data_i;
        CFG_DISC_CR:         cfg_d.disc_cr         = cfg_data_i;
        default:             cfg_d = cfg_q;  // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_size_mode <= SIZE_640X480;
      cfg_q.pixel_format    <= FMT_YU12;
      cfg_q.mirror_x        <= 1'b0;
      cfg_q.disc_luma       <= RST_DISC_LUMA;
      cfg_q.disc_cb         <= RST_DISC_CB;
      cfg_q.disc_cr         <= RST_DISC_CR;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/dcfp_pixel.sv
// Combinational pixel evaluation: disc centre scaling, distance tests and byte selection.
module dcfp_pixel (
  input  dcfp_pkg::cfg_t     cfg_i,
  input  dcfp_pkg::pix_in_t  pix_i,
  output dcfp_pkg::pix_out_t pix_o
);
  import dcfp_pkg::*;

  function automatic logic disc_hit(logic [9:0] x, logic [8:0] y, logic [9:0] w,
                                    logic [8:0] h, logic [9:0] cx, logic [8:0] cy,
                                    logic [9:0] rsq);
    logic signed [11:0] dx;
    logic signed [10:0] dy;
    logic signed [23:0] dx2;
    logic signed [21:0] dy2;
    logic [21:0]        dsq;
    dx   = $signed({2'b00, x}) - $signed({2'b00, cx});
    dy   = $signed({2'b00, y}) - $signed({2'b00, cy});
    dx2  = dx * dx;
    dy2  = dy * dy;
    dsq  = {1'b0, dx2[20:0]} + {1'b0, dy2[20:0]};
    return (x < w) && (y < h) && (dsq <= {12'd0, rsq});
  endfunction

  logic        has;
  logic        half_res;
  logic        yuyv;
  logic [10:0] ex;
  logic [9:0]  cx;
  logic [10:0] cy_num;
  logic [21:0] cy_prod;
  logic [8:0]  cy;
  logic [9:0]  w_full, w_chr;
  logic [8:0]  h_full, h_chr;
  logic [9:0]  rsq_full, rsq_chr;
  logic        full_a;
  logic [9:0]  xa, xb;
  logic        hit_a, hit_b;
  logic        hit, pair;

  assign half_res = (cfg_i.frame_size_mode == SIZE_320X240);
  assign yuyv  = (cfg_i.pixel_format == FMT_YUYV);
  assign has   = pix_i.pointer_present && (pix_i.pointer_x < PTR_X_LIMIT)
                 && (pix_i.pointer_y < PTR_Y_LIMIT);

  // Scale pointer to frame: x by W/1280 is a shift, y by H/720 is 2/3 or 1/3
  assign ex      = cfg_i.mirror_x ? 11'(PTR_X_MAX - pix_i.pointer_x[10:0])
                                  : pix_i.pointer_x[10:0];
  assign cx      = half_res ? 10'(ex >> 2) : 10'(ex >> 1);
  assign cy_num  = half_res ? {1'b0, pix_i.pointer_y[9:0]} : {pix_i.pointer_y[9:0], 1'b0};
  assign cy_prod = cy_num * RECIP3;
  assign cy      = cy_prod[Recip3Shift+8:Recip3Shift];

  assign w_full   = half_res ? WIDTH_HALF  : WIDTH_FULL;
  assign h_full   = half_res ? HEIGHT_HALF : HEIGHT_FULL;
  assign w_chr    = w_full >> 1;
  assign h_chr    = h_full >> 1;
  assign rsq_full = half_res ? RSQ_320 : RSQ_640;
  assign rsq_chr  = half_res ? RSQ_320_CHR : RSQ_640_CHR;

  // Evaluator A covers luma/chroma planes and the even pixel of a YUYV pair
  assign full_a = yuyv || (pix_i.plane == PLANE_Y);
  assign xa     = yuyv ? {pix_i.col[9:1], 1'b0} : pix_i.col;
  assign xb     = {pix_i.col[9:1], 1'b1};

  assign hit_a = has && (full_a
                 ? disc_hit(xa, pix_i.row, w_full, h_full, cx, cy, rsq_full)
                 : disc_hit(xa, pix_i.row, w_chr, h_chr, cx >> 1, cy >> 1, rsq_chr));
  assign hit_b = has && disc_hit(xb, pix_i.row, w_full, h_full, cx, cy, rsq_full);

  assign hit  = pix_i.col[0] ? hit_b : hit_a;
  assign pair = hit_a || hit_b;

  always_comb begin
    pix_o = '0;
    if (yuyv) begin
      pix_o.first_byte   = hit ? cfg_i.disc_luma : BG_LUMA;
      pix_o.second_byte  = pair ? (pix_i.col[0] ? cfg_i.disc_cr : cfg_i.disc_cb) : BG_CHROMA;
      pix_o.second_valid = 1'b1;
      pix_o.in_disc      = hit;
    end else begin
      case (pix_i.plane)
        PLANE_Y: begin
          pix_o.first_byte = hit_a ? cfg_i.disc_luma : BG_LUMA;
          pix_o.in_disc    = hit_a;
        end
        PLANE_U: begin
          pix_o.first_byte = hit_a ? cfg_i.disc_cb : BG_CHROMA;
          pix_o.in_disc    = hit_a;
        end
        PLANE_V: begin
          pix_o.first_byte = hit_a ? cfg_i.disc_cr : BG_CHROMA;
          pix_o.in_disc    = hit_a;
        end
        default: pix_o = '0;  // unused plane selector
      endcase
    end
  end

endmodule

// File: design/disc_cursor_frame_pixel_generator_top.sv
// Top level of the disc cursor frame pixel generator: config, input and result registers.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o/in_data_i) carries one pixel position per
//   transaction together with the pointer record; the output channel
//   (out_valid_o/out_ready_i/out_data_o) returns exactly one result per input, in order.
// - Config channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) writes one register per
//   transaction; cfg_ready_o is always high. Write config only while the block is idle.
// - Pipeline: an input register feeds one pass of combinational pixel logic (centre
//   scaling, two distance evaluators, byte select) into a result register.
// - Timing: an accepted input is held in the input register and moves into the result
//   register when that register is free; out_valid_o rises as the result register loads.
// - Throughput: 1 transaction per cycle while out_ready_i stays high, set by the single evaluation pass.
// - Stall: when out_ready_i is low the result register holds; the input register still
//   takes one more transaction if it is empty, then in_ready_o drops until space frees.
// - Reset: both valid flags clear and config returns to 640x480, YU12, no mirror,
//   disc colour Y 220 / U 219 / V 179.
module disc_cursor_frame_pixel_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dcfp_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dcfp_pkg::pix_out_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcfp_pkg::CfgIndexWidth-1:0]  cfg_index_i,
  input  logic [dcfp_pkg::CfgDataWidth-1:0]   cfg_data_i
);
  import dcfp_pkg::*;

  cfg_t     cfg;
  pix_in_t  in_q;
  logic     in_valid_q;
  pix_out_t pix;
  pix_out_t out_q;
  logic     out_valid_q;
  logic     out_free;
  logic     advance;

  dcfp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dcfp_pixel u_pixel (
    .cfg_i (cfg),
    .pix_i (in_q),
    .pix_o (pix)
  );

  // Result register frees when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  // Move the input register into the result register
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Payload registers: load on acceptance, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: design/dcfp_checker.sv
// Port-level checker for the disc cursor frame pixel generator, bound to the top level.
module dcfp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input dcfp_pkg::pix_out_t                  out_data_o,
  input logic                                cfg_ready_o
);
  import dcfp_pkg::*;

  // A stalled result stays presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

  // Planar results never carry a chroma byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.second_valid |-> out_data_o.second_byte == 8'd0)
    else $error("second byte set on a planar result");

  // Outside the disc, planar bytes are background or zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.second_valid && !out_data_o.in_disc |->
      out_data_o.first_byte == BG_LUMA || out_data_o.first_byte == BG_CHROMA ||
      out_data_o.first_byte == 8'd0)
    else $error("planar byte outside disc is not background");

  // Outside the disc, the packed luma byte is background luma
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.second_valid && !out_data_o.in_disc |->
      out_data_o.first_byte == BG_LUMA)
    else $error("packed luma outside disc is not background");

  // Config channel never back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("config channel not ready");

endmodule

bind disc_cursor_frame_pixel_generator_top dcfp_checker u_dcfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .cfg_ready_o (cfg_ready_o)
);
